// ===== rtl/brwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brwc_pkg: shared types and constants
// Widths, queue cell entry, and the control/status groups between the
// sequencer and the two monotonic queues.
// ----------------------------------------------------------------------------
package brwc_pkg;

	localparam int VAL_W = 32;   // sample width
	localparam int AGE_W = 32;   // distance back from the current sample
	localparam int LIM_W = 4;    // range limit register
	localparam int CNT_W = 32;   // windows ending at a sample
	localparam int TOT_W = 63;   // running total

	localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd2;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [AGE_W-1:0]        age_t;

	typedef struct packed {
		value_t value;
		age_t   age;
	} entry_t;

	// Queue control: load compares against a new sample, push does the
	// pop-back/insert, trim drops entries past the window and ages the rest.
	typedef struct packed {
		logic load;
		logic clear;
		logic push;
		logic trim;
		age_t wlim;
	} qctl_t;

	typedef struct packed {
		logic viol_any;
		age_t viol_age;
		logic full;
		age_t front_age;
	} qsts_t;

endpackage
`default_nettype wire

// ===== rtl/brwc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brwc_in_if: sample channel
// Valid/ready handshake carrying one sample word.
// ----------------------------------------------------------------------------
interface brwc_in_if;
	import brwc_pkg::*;

	logic   valid;
	logic   ready;
	value_t sample_value;
	logic   start_new;

	modport source (output valid, output sample_value, output start_new, input ready);
	modport sink (input valid, input sample_value, input start_new, output ready);

endinterface
`default_nettype wire

// ===== rtl/brwc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brwc_out_if: result channel
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface brwc_out_if;
	import brwc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] count_ending_here;
	logic [TOT_W-1:0] running_total;

	modport source (output valid, output count_ending_here, output running_total, input ready);
	modport sink (input valid, input count_ending_here, input running_total, output ready);

endinterface
`default_nettype wire

// ===== rtl/bounded_range_window_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_range_window_counter: longest bounded-range window per sample
// For each sample, finds the longest window ending there whose max - min is
// within range_limit, and reports its length and the saturating running sum.
// ----------------------------------------------------------------------------
//
//  channel    | dir | handshake      | word
//  -----------+-----+----------------+----------------------------------------
//  sample_ch  | in  | valid/ready    | sample_value (s32), start_new
//  result_ch  | out | valid/ready    | count_ending_here (u32), running_total (u63)
//  cfg        | in  | cfg_wr_en      | cfg_wr_data -> range_limit (u4)
//
//  Each word passes through the accept step, then window trim, min queue
//  update, max queue update and total. The two queues share the window
//  distance, so their updates run one after the other in the sequencer.
//  A new word is taken only in IDLE; a finished result sits in the output
//  register, so IDLE is reached while it waits. The total step holds only
//  when that register is still occupied. Reset: empty queues, range_limit 2.
//
// The window is tracked as a distance back from the current sample, and each
// queue entry stores its own age, so no absolute positions are kept. The max
// queue is a min queue over bit-inverted samples (~x reverses signed order).
// ----------------------------------------------------------------------------
module bounded_range_window_counter #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	brwc_in_if.sink                    sample_ch,
	brwc_out_if.source                 result_ch,
	input  logic                       cfg_wr_en,
	input  logic [brwc_pkg::LIM_W-1:0] cfg_wr_data
);
	import brwc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WIN  = 5'b00010,
		ST_MINQ = 5'b00100,
		ST_MAXQ = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	localparam age_t SPAN_CAP = {{(AGE_W-1){1'b1}}, 1'b0};

	state_t           st_q;
	logic [LIM_W-1:0] limit_q;
	age_t             span_q;      // current position minus window start
	age_t             win_q;       // window distance being narrowed
	logic [TOT_W-1:0] total_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_count_q;
	logic [TOT_W-1:0] out_total_q;

	logic             accept;
	logic             fin_go;
	qctl_t            min_ctl;
	qctl_t            max_ctl;
	qsts_t            min_sts;
	qsts_t            max_sts;
	age_t             w0;
	age_t             w_a;
	age_t             w1;
	age_t             cand_min;
	age_t             cand_max;
	logic [CNT_W-1:0] count;
	logic [TOT_W:0]   sum;
	logic [TOT_W-1:0] total_nxt;

	assign sample_ch.ready = (st_q == ST_IDLE);
	assign accept          = sample_ch.valid & sample_ch.ready;
	assign fin_go          = (st_q == ST_FIN) & (~out_valid_q | result_ch.ready);

	always_comb begin
		min_ctl.load  = accept;
		min_ctl.clear = sample_ch.start_new;
		min_ctl.push  = (st_q == ST_MINQ);
		min_ctl.trim  = fin_go;
		min_ctl.wlim  = win_q;
		max_ctl       = min_ctl;
		max_ctl.push  = (st_q == ST_MAXQ);
	end

	brwc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_min_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (min_ctl),
		.new_val (sample_ch.sample_value),
		.limit   (limit_q),
		.sts     (min_sts)
	);

	brwc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_max_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (max_ctl),
		.new_val (~sample_ch.sample_value),
		.limit   (limit_q),
		.sts     (max_sts)
	);

	// Window trim: the newest out-of-range entry in either queue moves the
	// start just past it; a window at full length loses its oldest sample.
	always_comb begin
		w0       = (span_q == '1) ? SPAN_CAP : span_q;
		cand_min = min_sts.viol_age - 1'b1;
		cand_max = max_sts.viol_age - 1'b1;
		w_a      = (min_sts.viol_any && (cand_min < w0)) ? cand_min : w0;
		w1       = (max_sts.viol_any && (cand_max < w_a)) ? cand_max : w_a;
	end

	always_comb begin
		count     = win_q + 1'b1;
		sum       = {1'b0, total_q} + (TOT_W+1)'(count);
		total_nxt = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_WIN;
					end
				end
				ST_WIN:  st_q <= ST_MINQ;
				ST_MINQ: st_q <= ST_MAXQ;
				ST_MAXQ: st_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			span_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept && sample_ch.start_new) begin
				span_q  <= '0;
				total_q <= '0;
			end else if (fin_go) begin
				span_q  <= count;
				total_q <= total_nxt;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// window distance: narrowed by violators, then by a full queue dropping
	// its front (the start moves just past the dropped entry)
	always_ff @(posedge clk) begin
		if (st_q == ST_WIN) begin
			win_q <= w1;
		end else if ((st_q == ST_MINQ) && min_sts.full) begin
			win_q <= min_sts.front_age - 1'b1;
		end else if ((st_q == ST_MAXQ) && max_sts.full) begin
			win_q <= max_sts.front_age - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_count_q <= count;
			out_total_q <= total_nxt;
		end
	end

	assign result_ch.valid             = out_valid_q;
	assign result_ch.count_ending_here = out_count_q;
	assign result_ch.running_total     = out_total_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == ST_WIN) && !sample_ch.ready)
		else $error("sample taken while previous word still in work");

	a_window_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN) |-> (win_q != '1))
		else $error("window distance reached all ones, count would wrap");

	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.count_ending_here != '0) &&
			(result_ch.running_total >= TOT_W'(result_ch.count_ending_here)))
		else $error("result word inconsistent");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_ch.valid) |-> ($past(st_q) == ST_FIN))
		else $error("result raised outside the total step");
`endif

endmodule
`default_nettype wire

// ===== rtl/brwc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brwc_cell: one monotonic queue cell
// Holds one (value, age) entry, compares it with the broadcast sample and
// takes its lower neighbor's entry when the queue shifts up.
// ----------------------------------------------------------------------------
module brwc_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brwc_pkg::qctl_t                ctl,
	input  brwc_pkg::value_t               cmp_val,
	input  logic [brwc_pkg::LIM_W-1:0]     limit,
	input  brwc_pkg::entry_t               lower_ent,
	input  logic                           lower_keep,
	input  logic                           shift,
	input  logic                           take_new,
	input  brwc_pkg::entry_t               new_ent,
	output brwc_pkg::entry_t               ent,
	output logic                           keep,
	output logic                           viol
);
	import brwc_pkg::*;

	entry_t ent_q;
	logic   valid_q;
	logic   lt_lo_q;
	logic   ge_x_q;

	logic signed [VAL_W+1:0] own_ext;
	logic signed [VAL_W+1:0] x_ext;
	logic                    lt_lo;
	logic                    ge_x;
	logic                    in_win;

	always_comb begin
		// value + limit < x  <=>  value < x - limit, no overflow at 34 bits
		own_ext = {{2{ent_q.value[VAL_W-1]}}, ent_q.value} + (VAL_W+2)'(limit);
		x_ext   = {{2{cmp_val[VAL_W-1]}}, cmp_val};
		lt_lo   = own_ext < x_ext;
		ge_x    = ent_q.value >= cmp_val;
		in_win  = ent_q.age <= ctl.wlim;
		keep    = valid_q & in_win & ~ge_x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load && ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			if (shift) begin
				valid_q <= lower_keep;
			end else if (take_new) begin
				valid_q <= 1'b1;
			end else begin
				valid_q <= keep;
			end
		end else if (ctl.trim) begin
			valid_q <= valid_q & in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lt_lo_q <= lt_lo;
			ge_x_q  <= ge_x;
		end
		if (ctl.push) begin
			if (shift) begin
				ent_q <= lower_ent;
			end else if (take_new) begin
				ent_q <= new_ent;
			end
		end else if (ctl.trim) begin
			ent_q.age <= ent_q.age + 1'b1;
		end
	end

	assign ent  = ent_q;
	assign viol = valid_q & lt_lo_q;

endmodule
`default_nettype wire

// ===== rtl/brwc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brwc_queue: monotonic minimum queue as a row of cells
// Entries form one contiguous block, front at the high end. A push either
// shifts the whole row up by one or drops the new entry just below the block.
// ----------------------------------------------------------------------------
module brwc_queue #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  brwc_pkg::qctl_t            ctl,
	input  brwc_pkg::value_t           new_val,
	input  logic [brwc_pkg::LIM_W-1:0] limit,
	output brwc_pkg::qsts_t            sts
);
	import brwc_pkg::*;

	value_t           new_val_q;
	entry_t           new_ent;
	entry_t           ent [DEPTH];
	entry_t           lower_ent [DEPTH];
	logic [DEPTH-1:0] keep;
	logic [DEPTH-1:0] lower_keep;
	logic [DEPTH-1:0] viol;
	logic [DEPTH-1:0] vsel;
	logic [DEPTH-1:0] take_new;
	logic             shift;
	logic             any_keep;
	age_t             viol_age;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			new_val_q <= new_val;
		end
	end

	always_comb begin
		new_ent.value = new_val_q;
		new_ent.age   = '0;
		shift         = keep[0];
		any_keep      = |keep;
		// new entry lands right below the block, or in cell 0 if empty
		take_new      = ~keep & (keep >> 1);
		take_new[0]   = take_new[0] | ~any_keep;
		lower_ent[0]  = new_ent;
		lower_keep[0] = 1'b1;
		for (int k = 1; k < DEPTH; k++) begin
			lower_ent[k]  = ent[k-1];
			lower_keep[k] = keep[k-1];
		end
	end

	// violators are a run at the front; the newest one sits at the run's low end
	always_comb begin
		vsel     = viol & ~(viol << 1);
		viol_age = '0;
		for (int k = 0; k < DEPTH; k++) begin
			viol_age = viol_age | (ent[k].age & {AGE_W{vsel[k]}});
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		brwc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_val    (new_val),
			.limit      (limit),
			.lower_ent  (lower_ent[k]),
			.lower_keep (lower_keep[k]),
			.shift      (shift),
			.take_new   (take_new[k]),
			.new_ent    (new_ent),
			.ent        (ent[k]),
			.keep       (keep[k]),
			.viol       (viol[k])
		);
	end

	always_comb begin
		sts.viol_any  = |viol;
		sts.viol_age  = viol_age;
		sts.full      = keep[0] & keep[DEPTH-1];
		sts.front_age = ent[DEPTH-1].age;
	end

endmodule
`default_nettype wire
